@@ hdl/grid_infection_spread_step_top_assert.svh @@
// ----------------------------------------------------------------------------
// grid_infection_spread_step_top_assert.svh
// Assertion macros for the grid infection spread step checker.
// ----------------------------------------------------------------------------
`ifndef GRID_INFECTION_SPREAD_STEP_TOP_ASSERT_SVH
`define GRID_INFECTION_SPREAD_STEP_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define GISS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("giss checker: same-cycle property failed");

// Check that cons holds in the cycle after ante.
`define GISS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("giss checker: next-cycle property failed");

`endif

@@ hdl/giss_pkg.sv @@
// ----------------------------------------------------------------------------
// giss_pkg
// Types and constants shared by the grid infection spread step block.
// ----------------------------------------------------------------------------
package giss_pkg;

    localparam int unsigned ADDR_W      = 20;
    localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
    localparam int unsigned GRID_W      = 11;
    localparam int unsigned DRAW_W      = 14;
    localparam int unsigned FLAGS_W     = 3;
    localparam int unsigned ADDED_W     = 4;
    localparam int unsigned COUNT_W     = 24;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 14;

    localparam int unsigned MAX_GRID_ROWS = 1024;
    localparam int unsigned MAX_GRID_COLS = 1024;
    localparam int unsigned DRAW_RANGE    = 10000;

    localparam int unsigned ROWS_RESET = 600;
    localparam int unsigned COLS_RESET = 800;
    localparam int unsigned THR_RESET  = 1000;

    // One quotient bit per divider step.
    localparam int unsigned DIV_STEPS  = ADDR_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int unsigned NBR_COUNT  = 8;
    localparam int unsigned NBR_IDX_W  = $clog2(NBR_COUNT);
    localparam int unsigned NBR_CNT_W  = NBR_IDX_W + 1;

    // Flag word bit positions and the word written for a fresh infection.
    localparam int unsigned FLAG_INFECTED = 0;
    localparam int unsigned FLAG_IMMUNE   = 1;
    localparam int unsigned FLAG_NEWLY    = 2;
    localparam logic [FLAGS_W-1:0] NEWLY_MARK = FLAGS_W'(1) << FLAG_NEWLY;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SPREAD = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_idx_t;

    // Neighbor positions in draw-field order.
    typedef enum logic [NBR_IDX_W-1:0] {
        NBR_UP         = 3'd0,
        NBR_UP_LEFT    = 3'd1,
        NBR_UP_RIGHT   = 3'd2,
        NBR_DOWN       = 3'd3,
        NBR_DOWN_LEFT  = 3'd4,
        NBR_DOWN_RIGHT = 3'd5,
        NBR_LEFT       = 3'd6,
        NBR_RIGHT      = 3'd7
    } nbr_pos_t;

    typedef enum logic [1:0] {
        STEP_ZERO  = 2'd0,
        STEP_MINUS = 2'd1,
        STEP_PLUS  = 2'd2
    } step_t;

    localparam step_t NBR_DR [NBR_COUNT] = '{
        STEP_MINUS, STEP_MINUS, STEP_MINUS, STEP_PLUS,
        STEP_PLUS,  STEP_PLUS,  STEP_ZERO,  STEP_ZERO
    };
    localparam step_t NBR_DC [NBR_COUNT] = '{
        STEP_ZERO,  STEP_MINUS, STEP_PLUS,  STEP_ZERO,
        STEP_MINUS, STEP_PLUS,  STEP_MINUS, STEP_PLUS
    };

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_WRITE  = 3'd1,
        ST_CLEAR  = 3'd2,
        ST_DIV    = 3'd3,
        ST_NBR    = 3'd4,
        ST_READ   = 3'd5,
        ST_RDWAIT = 3'd6,
        ST_RESP   = 3'd7
    } state_t;

    typedef struct packed {
        op_t                 operation;
        logic [ADDR_W-1:0]   cell_index;
        logic [FLAGS_W-1:0]  cell_flags_in;
        logic [DRAW_W-1:0]   draw_up;
        logic [DRAW_W-1:0]   draw_up_left;
        logic [DRAW_W-1:0]   draw_up_right;
        logic [DRAW_W-1:0]   draw_down;
        logic [DRAW_W-1:0]   draw_down_left;
        logic [DRAW_W-1:0]   draw_down_right;
        logic [DRAW_W-1:0]   draw_left;
        logic [DRAW_W-1:0]   draw_right;
    } giss_in_t;

    typedef struct packed {
        logic [FLAGS_W-1:0]  cell_flags_out;
        logic [ADDED_W-1:0]  new_infections;
        logic [COUNT_W-1:0]  infection_total;
    } giss_out_t;

    typedef struct packed {
        logic load;
        logic write_cell;
        logic read_cell;
        logic cap_flags;
        logic clear_count;
        logic div_step;
        logic nbr_step;
        logic out_load;
    } giss_cmd_t;

    typedef struct packed {
        op_t  op;
        logic div_last;
        logic in_grid;
        logic nbr_last;
        logic out_free;
    } giss_stat_t;

endpackage

@@ hdl/giss_ram.sv @@
// ----------------------------------------------------------------------------
// giss_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module giss_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1048576
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/giss_ctrl.sv @@
// ----------------------------------------------------------------------------
// giss_ctrl
// Sequencer: decodes an item and steps the datapath through its phases.
// ----------------------------------------------------------------------------
module giss_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  giss_pkg::giss_stat_t   stat,
    output giss_pkg::giss_cmd_t    cmd
);

    giss_pkg::state_t state_reg;
    giss_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= giss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            giss_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (stat.op)
                        giss_pkg::OP_WRITE:  state_next = giss_pkg::ST_WRITE;
                        giss_pkg::OP_SPREAD: state_next = giss_pkg::ST_DIV;
                        giss_pkg::OP_READ:   state_next = giss_pkg::ST_READ;
                        giss_pkg::OP_CLEAR:  state_next = giss_pkg::ST_CLEAR;
                    endcase
                end
            end
            giss_pkg::ST_WRITE: begin
                cmd.write_cell = 1'b1;
                state_next     = giss_pkg::ST_RESP;
            end
            giss_pkg::ST_CLEAR: begin
                cmd.clear_count = 1'b1;
                state_next      = giss_pkg::ST_RESP;
            end
            giss_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = giss_pkg::ST_NBR;
                end
            end
            giss_pkg::ST_NBR: begin
                // skip the sweep for a cell beyond the last row
                if (!stat.in_grid) begin
                    state_next = giss_pkg::ST_READ;
                end else begin
                    cmd.nbr_step = 1'b1;
                    if (stat.nbr_last) begin
                        state_next = giss_pkg::ST_READ;
                    end
                end
            end
            giss_pkg::ST_READ: begin
                cmd.read_cell = 1'b1;
                state_next    = giss_pkg::ST_RDWAIT;
            end
            giss_pkg::ST_RDWAIT: begin
                cmd.cap_flags = 1'b1;
                state_next    = giss_pkg::ST_RESP;
            end
            giss_pkg::ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = giss_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ hdl/giss_datapath.sv @@
// ----------------------------------------------------------------------------
// giss_datapath
// Config registers, row/column divider, neighbor sweep over the flag RAM,
// infection counter and output register.
// ----------------------------------------------------------------------------
module giss_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [giss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [giss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  giss_pkg::giss_in_t                   s_data,
    input  giss_pkg::giss_cmd_t                  cmd,
    output giss_pkg::giss_stat_t                 stat,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output giss_pkg::giss_out_t                  m_data
);

    localparam int unsigned AW = giss_pkg::ADDR_W;
    localparam int unsigned GW = giss_pkg::GRID_W;
    localparam int unsigned TW = giss_pkg::DRAW_W;
    localparam int unsigned FW = giss_pkg::FLAGS_W;

    // ---------------------------------------------------------------- config
    logic [GW-1:0] rows_cfg_reg;
    logic [GW-1:0] cols_cfg_reg;
    logic [TW-1:0] thr_cfg_reg;
    logic [GW-1:0] rows_c;
    logic [GW-1:0] cols_c;
    logic [TW-1:0] thr_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= GW'(giss_pkg::ROWS_RESET);
            cols_cfg_reg <= GW'(giss_pkg::COLS_RESET);
            thr_cfg_reg  <= TW'(giss_pkg::THR_RESET);
        end else if (cfg_wr_en) begin
            if (cfg_index == giss_pkg::CFG_GRID_ROWS) begin
                rows_cfg_reg <= cfg_wdata[GW-1:0];
            end else if (cfg_index == giss_pkg::CFG_GRID_COLS) begin
                cols_cfg_reg <= cfg_wdata[GW-1:0];
            end else if (cfg_index == giss_pkg::CFG_THRESHOLD) begin
                thr_cfg_reg <= cfg_wdata[TW-1:0];
            end
        end
    end

    // clamp to the legal ranges
    always_comb begin
        if (rows_cfg_reg == '0) begin
            rows_c = GW'(1);
        end else if (rows_cfg_reg > GW'(giss_pkg::MAX_GRID_ROWS)) begin
            rows_c = GW'(giss_pkg::MAX_GRID_ROWS);
        end else begin
            rows_c = rows_cfg_reg;
        end
        if (cols_cfg_reg == '0) begin
            cols_c = GW'(1);
        end else if (cols_cfg_reg > GW'(giss_pkg::MAX_GRID_COLS)) begin
            cols_c = GW'(giss_pkg::MAX_GRID_COLS);
        end else begin
            cols_c = cols_cfg_reg;
        end
        if (thr_cfg_reg > TW'(giss_pkg::DRAW_RANGE)) begin
            thr_c = TW'(giss_pkg::DRAW_RANGE);
        end else begin
            thr_c = thr_cfg_reg;
        end
    end

    // ------------------------------------------------------------ item hold
    giss_pkg::giss_in_t item_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
    end

    // --------------------------------------------------- restoring divider
    logic [AW-1:0]                  quo_reg;
    logic [AW-1:0]                  quo_next;
    logic [GW-1:0]                  rem_reg;
    logic [GW-1:0]                  rem_next;
    logic [giss_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [GW:0]                    trial;
    logic                           trial_ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[AW-1]};
        trial_ge = trial >= {1'b0, cols_c};
        rem_next = trial_ge ? GW'(trial - {1'b0, cols_c}) : GW'(trial);
        quo_next = {quo_reg[AW-2:0], trial_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.load) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quo_reg <= s_data.cell_index;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // after the divide: quo_reg is the row, rem_reg the column
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
    logic in_grid;
    logic [giss_pkg::NBR_COUNT-1:0] nbr_mask;

    function automatic logic step_ok(input giss_pkg::step_t s, input logic lo_ok,
                                     input logic hi_ok);
        case (s)
            giss_pkg::STEP_ZERO:  step_ok = 1'b1;
            giss_pkg::STEP_MINUS: step_ok = lo_ok;
            giss_pkg::STEP_PLUS:  step_ok = hi_ok;
            default:              step_ok = 1'b0;
        endcase
    endfunction

    always_comb begin
        in_grid  = quo_reg < AW'(rows_c);
        up_ok    = quo_reg != '0;
        down_ok  = ({1'b0, quo_reg} + 1'b1) < (AW + 1)'(rows_c);
        left_ok  = rem_reg != '0;
        right_ok = ({1'b0, rem_reg} + 1'b1) < {1'b0, cols_c};
        for (int k = 0; k < giss_pkg::NBR_COUNT; k++) begin
            nbr_mask[k] = step_ok(giss_pkg::NBR_DR[k], up_ok, down_ok) &
                          step_ok(giss_pkg::NBR_DC[k], left_ok, right_ok);
        end
    end

    // ------------------------------------------------------ neighbor sweep
    logic [giss_pkg::NBR_CNT_W-1:0] nbr_cnt_reg;
    logic [giss_pkg::NBR_IDX_W-1:0] nbr_k;
    logic                           nbr_rd;
    logic [AW-1:0]                  row_term;
    logic [AW-1:0]                  col_term;
    logic [AW-1:0]                  nbr_addr;
    logic                           eval_vld_reg;
    giss_pkg::nbr_pos_t             eval_k_reg;
    logic [AW-1:0]                  eval_addr_reg;

    assign nbr_k  = nbr_cnt_reg[giss_pkg::NBR_IDX_W-1:0];
    assign nbr_rd = cmd.nbr_step && (nbr_cnt_reg < giss_pkg::NBR_CNT_W'(giss_pkg::NBR_COUNT));

    // neighbor address = cell +/- cols +/- 1, modulo the store size
    always_comb begin
        case (giss_pkg::NBR_DR[nbr_k])
            giss_pkg::STEP_MINUS: row_term = AW'(0) - AW'(cols_c);
            giss_pkg::STEP_PLUS:  row_term = AW'(cols_c);
            default:              row_term = '0;
        endcase
        case (giss_pkg::NBR_DC[nbr_k])
            giss_pkg::STEP_MINUS: col_term = '1;
            giss_pkg::STEP_PLUS:  col_term = AW'(1);
            default:              col_term = '0;
        endcase
        nbr_addr = item_reg.cell_index + row_term + col_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbr_cnt_reg  <= '0;
            eval_vld_reg <= 1'b0;
        end else begin
            eval_vld_reg <= nbr_rd;
            if (cmd.load) begin
                nbr_cnt_reg <= '0;
            end else if (cmd.nbr_step) begin
                nbr_cnt_reg <= nbr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (nbr_rd) begin
            eval_k_reg    <= giss_pkg::nbr_pos_t'(nbr_k);
            eval_addr_reg <= nbr_addr;
        end
    end

    // --------------------------------------------------------- flag memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [FW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [FW-1:0] ram_q;
    logic [TW-1:0] eval_draw;
    logic          infect;

    always_comb begin
        unique case (eval_k_reg)
            giss_pkg::NBR_UP:         eval_draw = item_reg.draw_up;
            giss_pkg::NBR_UP_LEFT:    eval_draw = item_reg.draw_up_left;
            giss_pkg::NBR_UP_RIGHT:   eval_draw = item_reg.draw_up_right;
            giss_pkg::NBR_DOWN:       eval_draw = item_reg.draw_down;
            giss_pkg::NBR_DOWN_LEFT:  eval_draw = item_reg.draw_down_left;
            giss_pkg::NBR_DOWN_RIGHT: eval_draw = item_reg.draw_down_right;
            giss_pkg::NBR_LEFT:       eval_draw = item_reg.draw_left;
            giss_pkg::NBR_RIGHT:      eval_draw = item_reg.draw_right;
        endcase
        // mark only a neighbor with no flag set at all
        infect = eval_vld_reg && nbr_mask[eval_k_reg] && (ram_q == '0) && (eval_draw < thr_c);

        ram_we    = cmd.write_cell || infect;
        ram_waddr = infect ? eval_addr_reg : item_reg.cell_index;
        ram_wdata = infect ? giss_pkg::NEWLY_MARK : item_reg.cell_flags_in;
        ram_re    = cmd.read_cell || nbr_rd;
        ram_raddr = cmd.read_cell ? item_reg.cell_index : nbr_addr;
    end

    giss_ram #(
        .WIDTH (FW),
        .DEPTH (giss_pkg::STORE_DEPTH)
    ) u_flag_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    // ------------------------------------------------------------- results
    logic [giss_pkg::ADDED_W-1:0] added_reg;
    logic [giss_pkg::COUNT_W-1:0] count_reg;
    logic [FW-1:0]                res_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear_count) begin
            count_reg <= '0;
        end else if (infect && (count_reg != giss_pkg::COUNT_MAX)) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            added_reg <= '0;
        end else if (infect) begin
            added_reg <= added_reg + 1'b1;
        end
        if (cmd.write_cell) begin
            res_flags_reg <= item_reg.cell_flags_in;
        end else if (cmd.cap_flags) begin
            res_flags_reg <= ram_q;
        end else if (cmd.clear_count) begin
            res_flags_reg <= '0;
        end
    end

    // ----------------------------------------------------- output register
    logic                m_valid_reg;
    giss_pkg::giss_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.cell_flags_out  <= res_flags_reg;
            m_data_reg.new_infections  <= added_reg;
            m_data_reg.infection_total <= count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.op       = s_data.operation;
        stat.div_last = div_cnt_reg == giss_pkg::DIV_CNT_W'(giss_pkg::DIV_STEPS - 1);
        stat.in_grid  = in_grid;
        stat.nbr_last = nbr_cnt_reg == giss_pkg::NBR_CNT_W'(giss_pkg::NBR_COUNT);
        stat.out_free = !m_valid_reg || m_ready;
    end

endmodule

@@ hdl/grid_infection_spread_step_top.sv @@
// ----------------------------------------------------------------------------
// grid_infection_spread_step_top
// One item at a time: the next item can be taken from the cycle after the
//   controller loads the previous result into the output register. A spread
//   is shorter when the cell lies beyond the last row, as the neighbor sweep
//   is skipped. Spread time is set by the 20-step row/column divider and the
//   single RAM read port.
// Reset: synchronous, active low; clears the count, the control state and
//   loads the register defaults. The flag RAM is not cleared.
// ----------------------------------------------------------------------------
module grid_infection_spread_step_top (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [giss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [giss_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // item channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  giss_pkg::giss_in_t               s_data,

    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output giss_pkg::giss_out_t              m_data
);

    // The controller owns the sequencing: it takes one transfer on the item
    // channel, then walks write, clear, read or spread phases. A spread item
    // first divides the cell index by the column count (one quotient bit
    // per cycle) to find row and column, then, unless the cell lies beyond
    // the last row, sweeps the eight neighbors. The sweep overlaps the RAM
    // read of one neighbor with the check and write-back of the one before.
    // The center cell is read last to report its flags.
    giss_pkg::giss_cmd_t  cmd;
    giss_pkg::giss_stat_t stat;

    giss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the registers, divider, flag RAM, counters and the
    // output register. The output register decouples the result channel:
    // hold the result until its transfer, and let the controller load the
    // next one only once the register is free.
    giss_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hdl/giss_checker.sv @@
// ----------------------------------------------------------------------------
// giss_checker
// Port-level checks for the grid infection spread step block.
// ----------------------------------------------------------------------------
`include "grid_infection_spread_step_top_assert.svh"

module giss_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input giss_pkg::giss_out_t  m_data
);

    // a stalled result stays put
    `GISS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one item in flight: ready drops after each input transfer
    `GISS_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)

    // at most eight neighbors can be marked
    `GISS_ASSERT_IMPLIES(a_added_range, m_valid, m_data.new_infections <= 4'd8)

    // any marking leaves a nonzero running count
    `GISS_ASSERT_IMPLIES(a_total_covers, m_valid && (m_data.new_infections != 4'd0), m_data.infection_total != 24'd0)

endmodule

bind grid_infection_spread_step_top giss_checker u_giss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_infection_spread_step_top. A queue of items,
// filled phase by phase under several grid sizes and thresholds, feeds a
// valid/ready driver. Each accepted item runs through a behavioral copy of
// the flag stores and infection count, and the result channel monitor checks
// every returned result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 40;     // longest item latency plus margin
    localparam int PHASE_ITEMS    = 90;
    localparam int HOLD_AFTER     = 150;    // results before the long hold-off
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PERCENT   = 11;

    localparam logic [giss_pkg::FLAGS_W-1:0] F_NONE     = '0;
    localparam logic [giss_pkg::FLAGS_W-1:0] F_INFECTED =
        giss_pkg::FLAGS_W'(1) << giss_pkg::FLAG_INFECTED;
    localparam logic [giss_pkg::FLAGS_W-1:0] F_IMMUNE   =
        giss_pkg::FLAGS_W'(1) << giss_pkg::FLAG_IMMUNE;
    localparam logic [giss_pkg::FLAGS_W-1:0] F_ALL      = '1;

    // one row down and the first cell past the grid at the reset sizes
    localparam logic [giss_pkg::ADDR_W-1:0] ROW_STEP   =
        giss_pkg::ADDR_W'(giss_pkg::COLS_RESET);
    localparam logic [giss_pkg::ADDR_W-1:0] GRID_CELLS =
        giss_pkg::ADDR_W'(giss_pkg::ROWS_RESET * giss_pkg::COLS_RESET);

    typedef logic [giss_pkg::NBR_COUNT-1:0][giss_pkg::DRAW_W-1:0] draw_set_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O
    // ------------------------------------------------------------------------
    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [giss_pkg::CFG_IDX_W-1:0]  cfg_index = giss_pkg::CFG_GRID_ROWS;
    logic [giss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    giss_pkg::giss_in_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    giss_pkg::giss_out_t             m_data;

    grid_infection_spread_step_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Behavioral copy of the block: flag stores, running count, registers
    // ------------------------------------------------------------------------
    logic [giss_pkg::FLAGS_W-1:0] cell_flags_mem [int unsigned];
    logic [giss_pkg::COUNT_W-1:0] infection_tally = '0;
    int                           rows_reg = giss_pkg::ROWS_RESET;
    int                           cols_reg = giss_pkg::COLS_RESET;
    int                           thr_reg  = giss_pkg::THR_RESET;

    // Stimulus bookkeeping and statistics
    giss_pkg::giss_in_t           items_to_send [$];
    giss_pkg::giss_out_t          results_due [$];
    bit                           cell_written [int unsigned];
    logic [giss_pkg::ADDR_W-1:0]  written_list [$];
    int                           items_queued   = 0;
    int                           results_seen   = 0;
    int                           fail_count     = 0;
    int                           marks_total    = 0;
    int                           grid_settings  = 1;
    int                           op_count [4]   = '{0, 0, 0, 0};
    bit                           steady         = 1'b0;  // suppress random idling
    bit                           hold_done      = 1'b0;
    int                           hold_left      = 0;
    int                           quiet_cycles   = 0;

    function automatic int grid_rows_used();
        if (rows_reg < 1) return 1;
        if (rows_reg > giss_pkg::MAX_GRID_ROWS) return giss_pkg::MAX_GRID_ROWS;
        return rows_reg;
    endfunction

    function automatic int grid_cols_used();
        if (cols_reg < 1) return 1;
        if (cols_reg > giss_pkg::MAX_GRID_COLS) return giss_pkg::MAX_GRID_COLS;
        return cols_reg;
    endfunction

    function automatic int threshold_used();
        return (thr_reg > giss_pkg::DRAW_RANGE) ? giss_pkg::DRAW_RANGE : thr_reg;
    endfunction

    // Store address of neighbor k of a cell; 0 when it falls off the grid or
    // the cell itself lies beyond the last row.
    function automatic bit neighbour_addr(logic [giss_pkg::ADDR_W-1:0] idx, int k,
                                          output logic [giss_pkg::ADDR_W-1:0] addr);
        int rows;
        int cols;
        int r;
        int c;
        rows = grid_rows_used();
        cols = grid_cols_used();
        r    = int'(idx) / cols;
        c    = int'(idx) % cols;
        addr = '0;
        if (r >= rows) return 1'b0;
        case (giss_pkg::nbr_pos_t'(k))
            giss_pkg::NBR_UP:         r = r - 1;
            giss_pkg::NBR_UP_LEFT:    begin r = r - 1; c = c - 1; end
            giss_pkg::NBR_UP_RIGHT:   begin r = r - 1; c = c + 1; end
            giss_pkg::NBR_DOWN:       r = r + 1;
            giss_pkg::NBR_DOWN_LEFT:  begin r = r + 1; c = c - 1; end
            giss_pkg::NBR_DOWN_RIGHT: begin r = r + 1; c = c + 1; end
            giss_pkg::NBR_LEFT:       c = c - 1;
            default:                  c = c + 1;
        endcase
        if (r < 0 || c < 0 || r >= rows || c >= cols) return 1'b0;
        addr = giss_pkg::ADDR_W'(r * cols + c);
        return 1'b1;
    endfunction

    function automatic logic [giss_pkg::DRAW_W-1:0] draw_for(giss_pkg::giss_in_t it, int k);
        case (giss_pkg::nbr_pos_t'(k))
            giss_pkg::NBR_UP:         return it.draw_up;
            giss_pkg::NBR_UP_LEFT:    return it.draw_up_left;
            giss_pkg::NBR_UP_RIGHT:   return it.draw_up_right;
            giss_pkg::NBR_DOWN:       return it.draw_down;
            giss_pkg::NBR_DOWN_LEFT:  return it.draw_down_left;
            giss_pkg::NBR_DOWN_RIGHT: return it.draw_down_right;
            giss_pkg::NBR_LEFT:       return it.draw_left;
            default:                  return it.draw_right;
        endcase
    endfunction

    function automatic logic [giss_pkg::FLAGS_W-1:0] flags_at(logic [giss_pkg::ADDR_W-1:0] a);
        return cell_flags_mem.exists(a) ? cell_flags_mem[a] : F_NONE;
    endfunction

    // Advance the behavioral state by one item and return its result.
    function automatic giss_pkg::giss_out_t apply_step(giss_pkg::giss_in_t it);
        giss_pkg::giss_out_t         res;
        logic [giss_pkg::ADDR_W-1:0] a;
        int                          added;
        res   = '0;
        added = 0;
        case (it.operation)
            giss_pkg::OP_WRITE: begin
                cell_flags_mem[it.cell_index] = it.cell_flags_in;
                res.cell_flags_out = it.cell_flags_in;
            end
            giss_pkg::OP_SPREAD: begin
                for (int k = 0; k < giss_pkg::NBR_COUNT; k++) begin
                    if (neighbour_addr(it.cell_index, k, a) && flags_at(a) == F_NONE &&
                        draw_for(it, k) < threshold_used()) begin
                        cell_flags_mem[a] = giss_pkg::NEWLY_MARK;
                        added++;
                        if (infection_tally != giss_pkg::COUNT_MAX) infection_tally++;
                    end
                end
                res.cell_flags_out = flags_at(it.cell_index);
            end
            giss_pkg::OP_READ: begin
                res.cell_flags_out = flags_at(it.cell_index);
            end
            default: begin
                infection_tally = '0;
            end
        endcase
        marks_total           += added;
        res.new_infections     = giss_pkg::ADDED_W'(added);
        res.infection_total    = infection_tally;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Item driver: when the slot is free, offer the next pending item unless
    // a random idle is drawn; predict each item on the edge where its transfer completes.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                results_due.push_back(apply_step(s_data));
                op_count[s_data.operation]++;
            end
            if (items_to_send.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                s_valid <= 1'b1;
                s_data  <= items_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest prediction and
    // drive m_ready, including one long hold-off that backs up the block.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        giss_pkg::giss_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result with nothing pending: flags %0d new %0d total %0d",
                                 $realtime, m_data.cell_flags_out, m_data.new_infections,
                                 m_data.infection_total);
                end else begin
                    want = results_due.pop_front();
                    if (want.cell_flags_out !== m_data.cell_flags_out ||
                        want.new_infections !== m_data.new_infections ||
                        want.infection_total !== m_data.infection_total) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $write("[%0t] result %0d mismatch, expected/actual:",
                                   $realtime, results_seen);
                            $display(" flags %0d/%0d new %0d/%0d total %0d/%0d",
                                     want.cell_flags_out, m_data.cell_flags_out,
                                     want.new_infections, m_data.new_infections,
                                     want.infection_total, m_data.infection_total);
                        end
                    end
                end
            end
            // Hold off once for a long stretch so the sender stalls on s_ready.
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Track register writes on the edge the block samples them.
    always @(posedge aclk) begin
        if (aresetn && cfg_wr_en) begin
            case (giss_pkg::cfg_idx_t'(cfg_index))
                giss_pkg::CFG_GRID_ROWS: rows_reg = int'(cfg_wdata[giss_pkg::GRID_W-1:0]);
                giss_pkg::CFG_GRID_COLS: cols_reg = int'(cfg_wdata[giss_pkg::GRID_W-1:0]);
                giss_pkg::CFG_THRESHOLD: thr_reg  = int'(cfg_wdata);
                default:                 ;
            endcase
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles, %0d results pending",
                         $realtime, WATCHDOG_LIMIT, results_due.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    function automatic logic [giss_pkg::DRAW_W-1:0] rand_draw();
        int thr;
        thr = threshold_used();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return giss_pkg::DRAW_W'((thr == 0) ? 0 : thr - 1);
            2:       return giss_pkg::DRAW_W'(thr);
            3:       return giss_pkg::DRAW_W'($urandom_range(giss_pkg::DRAW_RANGE + 1,
                                                             (1 << giss_pkg::DRAW_W) - 1));
            default: return giss_pkg::DRAW_W'($urandom_range(0, giss_pkg::DRAW_RANGE));
        endcase
    endfunction

    function automatic draw_set_t rand_draws();
        draw_set_t d;
        for (int k = 0; k < giss_pkg::NBR_COUNT; k++) d[k] = rand_draw();
        return d;
    endfunction

    // Mostly clear cells so that spreads find neighbors to mark.
    function automatic logic [giss_pkg::FLAGS_W-1:0] rand_flags();
        return $urandom_range(0, 1) ? F_NONE : giss_pkg::FLAGS_W'($urandom_range(0, 7));
    endfunction

    function automatic void queue_item(giss_pkg::op_t op, logic [giss_pkg::ADDR_W-1:0] idx,
                                       logic [giss_pkg::FLAGS_W-1:0] flags, draw_set_t d);
        giss_pkg::giss_in_t it;
        it.operation       = op;
        it.cell_index      = idx;
        it.cell_flags_in   = flags;
        it.draw_up         = d[giss_pkg::NBR_UP];
        it.draw_up_left    = d[giss_pkg::NBR_UP_LEFT];
        it.draw_up_right   = d[giss_pkg::NBR_UP_RIGHT];
        it.draw_down       = d[giss_pkg::NBR_DOWN];
        it.draw_down_left  = d[giss_pkg::NBR_DOWN_LEFT];
        it.draw_down_right = d[giss_pkg::NBR_DOWN_RIGHT];
        it.draw_left       = d[giss_pkg::NBR_LEFT];
        it.draw_right      = d[giss_pkg::NBR_RIGHT];
        items_to_send.push_back(it);
        items_queued++;
        if (op == giss_pkg::OP_WRITE && !cell_written.exists(idx)) begin
            cell_written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endfunction

    // Write any cell the spread would look at that has never been written,
    // then queue the spread itself.
    function automatic void queue_spread(logic [giss_pkg::ADDR_W-1:0] idx, draw_set_t d);
        logic [giss_pkg::ADDR_W-1:0] a;
        if (!cell_written.exists(idx))
            queue_item(giss_pkg::OP_WRITE, idx, rand_flags(), rand_draws());
        for (int k = 0; k < giss_pkg::NBR_COUNT; k++) begin
            if (neighbour_addr(idx, k, a) && !cell_written.exists(a))
                queue_item(giss_pkg::OP_WRITE, a, rand_flags(), rand_draws());
        end
        queue_item(giss_pkg::OP_SPREAD, idx, giss_pkg::FLAGS_W'($urandom_range(0, 7)), d);
    endfunction

    function automatic logic [giss_pkg::ADDR_W-1:0] pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic void queue_directed();
        draw_set_t d;
        // corner cell: only the clear, unmarked neighbor gets infected
        queue_item(giss_pkg::OP_WRITE, '0, F_NONE, rand_draws());
        queue_item(giss_pkg::OP_WRITE, giss_pkg::ADDR_W'(1), F_INFECTED, rand_draws());
        queue_item(giss_pkg::OP_WRITE, ROW_STEP, F_IMMUNE, rand_draws());
        queue_item(giss_pkg::OP_WRITE, ROW_STEP + 1'b1, F_NONE, rand_draws());
        queue_spread('0, '0);
        // interior cell: flagged neighbors of each kind and draws around the threshold
        queue_item(giss_pkg::OP_WRITE, giss_pkg::ADDR_W'(2), F_NONE, rand_draws());
        queue_item(giss_pkg::OP_WRITE, ROW_STEP + 2'd2, giss_pkg::NEWLY_MARK, rand_draws());
        queue_item(giss_pkg::OP_WRITE, ROW_STEP << 1, F_NONE, rand_draws());
        queue_item(giss_pkg::OP_WRITE, (ROW_STEP << 1) + 1'b1, F_ALL, rand_draws());
        queue_item(giss_pkg::OP_WRITE, (ROW_STEP << 1) + 2'd2, F_NONE, rand_draws());
        d                                = '0;
        d[giss_pkg::NBR_UP]              = giss_pkg::DRAW_W'(giss_pkg::DRAW_RANGE);
        d[giss_pkg::NBR_UP_LEFT]         = giss_pkg::DRAW_W'(giss_pkg::THR_RESET - 1);
        d[giss_pkg::NBR_UP_RIGHT]        = giss_pkg::DRAW_W'(giss_pkg::THR_RESET);
        d[giss_pkg::NBR_DOWN_LEFT]       = '1;
        queue_spread(ROW_STEP + 1'b1, d);
        queue_item(giss_pkg::OP_READ, ROW_STEP + 1'b1, F_ALL, rand_draws());
        // cells beyond the last grid row mark nothing
        queue_item(giss_pkg::OP_WRITE, GRID_CELLS, F_IMMUNE, rand_draws());
        queue_spread(GRID_CELLS, '0);
        queue_item(giss_pkg::OP_WRITE, '1, F_ALL, rand_draws());
        queue_item(giss_pkg::OP_READ, '1, F_NONE, rand_draws());
        queue_spread('1, '0);
        queue_item(giss_pkg::OP_CLEAR, '1, F_ALL, '1);
        // last cell of the grid, bottom-right corner
        queue_spread(GRID_CELLS - 1'b1, '0);
        queue_item(giss_pkg::OP_READ, '0, F_NONE, rand_draws());
    endfunction

    function automatic void queue_random(int goal);
        int                          stop;
        int                          cells;
        int                          pick;
        logic [giss_pkg::ADDR_W-1:0] idx;
        stop  = items_queued + goal;
        cells = grid_rows_used() * grid_cols_used();
        while (items_queued < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 1)) idx = pick_written();
                else idx = giss_pkg::ADDR_W'($urandom_range(0, cells - 1));
                queue_spread(idx, rand_draws());
            end else if (pick < 65) begin
                queue_spread(giss_pkg::ADDR_W'($urandom), rand_draws());
            end else if (pick < 73) begin
                idx = giss_pkg::ADDR_W'($urandom_range(0, cells - 1));
                queue_item(giss_pkg::OP_WRITE, idx, rand_flags(), rand_draws());
            end else if (pick < 80) begin
                queue_item(giss_pkg::OP_WRITE, giss_pkg::ADDR_W'($urandom),
                           giss_pkg::FLAGS_W'($urandom_range(0, 7)), rand_draws());
            end else if (pick < 94) begin
                queue_item(giss_pkg::OP_READ, pick_written(),
                           giss_pkg::FLAGS_W'($urandom_range(0, 7)), rand_draws());
            end else begin
                queue_item(giss_pkg::OP_CLEAR, giss_pkg::ADDR_W'($urandom),
                           giss_pkg::FLAGS_W'($urandom_range(0, 7)), rand_draws());
            end
        end
    endfunction

    // Wait until every pending item is sent and every result is back, then
    // let the block settle before registers change.
    task automatic wait_drained();
        while (items_to_send.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back, then drop the write enable.
    task automatic set_grid(logic [giss_pkg::CFG_DATA_W-1:0] rows,
                            logic [giss_pkg::CFG_DATA_W-1:0] cols,
                            logic [giss_pkg::CFG_DATA_W-1:0] thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= giss_pkg::CFG_GRID_ROWS;
        cfg_wdata <= rows;
        @(posedge aclk);
        cfg_index <= giss_pkg::CFG_GRID_COLS;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_index <= giss_pkg::CFG_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        grid_settings++;
    endtask

    task automatic run_phase(logic [giss_pkg::CFG_DATA_W-1:0] rows,
                             logic [giss_pkg::CFG_DATA_W-1:0] cols,
                             logic [giss_pkg::CFG_DATA_W-1:0] thr);
        set_grid(rows, cols, thr);
        queue_random(PHASE_ITEMS);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // First phase runs on the reset register values.
        queue_directed();
        queue_random(PHASE_ITEMS);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // single cell, no neighbors
        run_phase(1, 1, giss_pkg::CFG_DATA_W'(giss_pkg::DRAW_RANGE));
        // full grid, nothing infects
        run_phase(giss_pkg::CFG_DATA_W'(giss_pkg::MAX_GRID_ROWS),
                  giss_pkg::CFG_DATA_W'(giss_pkg::MAX_GRID_COLS), 0);
        // out of range, all clamped
        run_phase('1, 0, '1);
        // back-to-back transfers
        steady = 1'b1;
        run_phase(5, 7, giss_pkg::CFG_DATA_W'(giss_pkg::DRAW_RANGE / 2));
        steady = 1'b0;
        run_phase(3, 2, 8000);
        run_phase(giss_pkg::CFG_DATA_W'($urandom_range(1, 40)),
                  giss_pkg::CFG_DATA_W'($urandom_range(1, 40)),
                  giss_pkg::CFG_DATA_W'($urandom_range(0, giss_pkg::DRAW_RANGE)));
        run_phase(giss_pkg::CFG_DATA_W'($urandom_range(1, giss_pkg::MAX_GRID_ROWS)),
                  giss_pkg::CFG_DATA_W'($urandom_range(1, giss_pkg::MAX_GRID_COLS)),
                  giss_pkg::CFG_DATA_W'(giss_pkg::DRAW_RANGE - 1));

        fail_count += results_due.size();
        $display("Covered %0d items under %0d grid settings: %0d writes, %0d spreads,",
                 results_seen, grid_settings, op_count[giss_pkg::OP_WRITE],
                 op_count[giss_pkg::OP_SPREAD]);
        $display("  %0d reads, %0d count clears; spreads marked %0d neighbors in all.",
                 op_count[giss_pkg::OP_READ], op_count[giss_pkg::OP_CLEAR], marks_total);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/giss_pkg.sv
hdl/giss_ram.sv
hdl/giss_ctrl.sv
hdl/giss_datapath.sv
hdl/grid_infection_spread_step_top.sv
hdl/giss_checker.sv
sim/testbench.sv
